FILE: src/itdt_pkg.sv
// Shared constants, types and helpers for the integer to decimal text converter.
`timescale 1ns / 1ps
package itdt_pkg;

    // Width of the converted two's complement integer (8..64).
    localparam int VALUE_WIDTH = 64;
    localparam int IN_WIDTH    = 64;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // Decimal digits needed for the largest magnitude, 2^(w-1).
    function automatic int num_digits(input int w);
        logic [63:0] p;
        int          n;
        begin
            p = 64'd1 << (w - 1);
            n = 0;
            for (int i = 0; i < 20; i++) begin
                if (p != 64'd0) begin
                    p = p / 64'd10;
                    n = n + 1;
                end
            end
            return n;
        end
    endfunction

    localparam int NDIG   = num_digits(VALUE_WIDTH);
    localparam int BCD_W  = 4 * NDIG;
    localparam int DCNT_W = $clog2(NDIG + 1);
    localparam int BCNT_W = $clog2(VALUE_WIDTH);

    // One classified item: sign and magnitude.
    typedef struct packed {
        logic                   neg;
        logic [VALUE_WIDTH-1:0] mag;
    } item_t;

endpackage

FILE: src/int_to_decimal_text_top.sv
// Signed integer to decimal ASCII text converter, top level.
`timescale 1ns / 1ps
// Converts each signed value into its decimal text, one ASCII character per
// output transfer, most significant first, with a leading '-' for negative
// values and last_char set on the final digit. Conversion is one shift-and-
// add-3 pass per magnitude bit, followed by one step per digit position (19
// at the 64-bit width), each either a leading zero dropped or a character
// sent, with the '-' of a negative value sent first; a character waits while
// the output is stalled. The converter holds one item at a time and takes the
// next only after the last character of the current one is registered. A
// two-entry queue and an input register let up to three further values be
// taken while one is being converted.
module int_to_decimal_text_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [itdt_pkg::IN_WIDTH-1:0] value,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic [7:0]                    char_code,
    output logic                          last_char,
    output logic                          out_valid,
    input  logic                          out_ready
);

    itdt_pkg::item_t front_item;
    logic            front_valid;
    logic            front_ready;
    itdt_pkg::item_t q_item;
    logic            q_valid;
    logic            q_ready;

    itdt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    itdt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (q_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready)
    );

    itdt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .char_code  (char_code),
        .last_char  (last_char),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

FILE: src/itdt_front.sv
// Input stage: takes a value, splits it into sign and magnitude, registers it.
`timescale 1ns / 1ps
module itdt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [itdt_pkg::IN_WIDTH-1:0]   value,
    input  logic                            in_valid,
    output logic                            in_ready,
    output itdt_pkg::item_t                 item,
    output logic                            item_valid,
    input  logic                            item_ready
);

    logic [itdt_pkg::VALUE_WIDTH-1:0] v;
    itdt_pkg::item_t                  item_reg;
    itdt_pkg::item_t                  item_next;
    logic                             valid_reg;
    logic                             valid_next;

    assign v        = value[itdt_pkg::VALUE_WIDTH-1:0];
    assign in_ready = !valid_reg || item_ready;

    always_comb
    begin
        item_next.neg = v[itdt_pkg::VALUE_WIDTH-1];
        // Two's complement negation; the most negative value maps to 2^(w-1).
        item_next.mag = item_next.neg ? (~v + 1'b1) : v;
        valid_next    = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

FILE: src/itdt_queue.sv
// Two-entry queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module itdt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  itdt_pkg::item_t wr_item,
    input  logic            wr_valid,
    output logic            wr_ready,
    output itdt_pkg::item_t rd_item,
    output logic            rd_valid,
    input  logic            rd_ready
);

    itdt_pkg::item_t mem [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_item  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: src/itdt_back.sv
// Back end: bit-serial binary to BCD conversion, then character emission.
`timescale 1ns / 1ps
module itdt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  itdt_pkg::item_t item,
    input  logic            item_valid,
    output logic            item_ready,
    output logic [7:0]      char_code,
    output logic            last_char,
    output logic            out_valid,
    input  logic            out_ready
);

    typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIGN, ST_EMIT} state_t;

    state_t                             state_reg,   state_next;
    logic [itdt_pkg::VALUE_WIDTH-1:0]   mag_reg,     mag_next;
    logic                               neg_reg,     neg_next;
    logic [itdt_pkg::BCD_W-1:0]         bcd_reg,     bcd_next;
    logic [itdt_pkg::BCNT_W-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [itdt_pkg::DCNT_W-1:0]        dig_cnt_reg, dig_cnt_next;
    logic                               started_reg, started_next;
    logic [7:0]                         char_reg,    char_next;
    logic                               last_reg,    last_next;
    logic                               ovalid_reg,  ovalid_next;

    logic [itdt_pkg::BCD_W-1:0]         bcd_adj;
    logic [3:0]                         top_digit;
    logic                               slot_free;

    // Add 3 to every digit of 5 or more before the shift.
    always_comb
    begin
        for (int i = 0; i < itdt_pkg::NDIG; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
    end

    assign top_digit  = bcd_reg[itdt_pkg::BCD_W-1 -: 4];
    assign slot_free  = !ovalid_reg || out_ready;
    assign item_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        bcd_next     = bcd_reg;
        bit_cnt_next = bit_cnt_reg;
        dig_cnt_next = dig_cnt_reg;
        started_next = started_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        ovalid_next  = ovalid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    mag_next     = item.mag;
                    neg_next     = item.neg;
                    bcd_next     = '0;
                    bit_cnt_next = '0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next = {bcd_adj[itdt_pkg::BCD_W-2:0],
                            mag_reg[itdt_pkg::VALUE_WIDTH-1]};
                mag_next = {mag_reg[itdt_pkg::VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == itdt_pkg::BCNT_W'(itdt_pkg::VALUE_WIDTH - 1))
                begin
                    dig_cnt_next = itdt_pkg::DCNT_W'(itdt_pkg::NDIG);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    char_next   = itdt_pkg::ASCII_MINUS;
                    last_next   = 1'b0;
                    ovalid_next = 1'b1;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!started_reg && top_digit == 4'd0 && dig_cnt_reg != 1)
                begin
                    // leading zero: drop it without a transfer
                    bcd_next     = {bcd_reg[itdt_pkg::BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (slot_free)
                begin
                    char_next    = itdt_pkg::ASCII_ZERO + {4'd0, top_digit};
                    last_next    = (dig_cnt_reg == 1);
                    ovalid_next  = 1'b1;
                    started_next = 1'b1;
                    bcd_next     = {bcd_reg[itdt_pkg::BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == 1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mag_reg     <= '0;
            neg_reg     <= 1'b0;
            bcd_reg     <= '0;
            bit_cnt_reg <= '0;
            dig_cnt_reg <= '0;
            started_reg <= 1'b0;
            char_reg    <= '0;
            last_reg    <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            bcd_reg     <= bcd_next;
            bit_cnt_reg <= bit_cnt_next;
            dig_cnt_reg <= dig_cnt_next;
            started_reg <= started_next;
            char_reg    <= char_next;
            last_reg    <= last_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    assign char_code = char_reg;
    assign last_char = last_reg;
    assign out_valid = ovalid_reg;

endmodule
